FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the frame deframer controller and datapath.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int FRAME_LEN_W = 7;
  localparam int POS_W       = 6;

  // start byte value after reset
  localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;

  // controller states: parse phases, then replay
  typedef enum logic [2:0] {
    ST_START,
    ST_TYPE,
    ST_ID,
    ST_LEN,
    ST_PAYLOAD,
    ST_CHECK,
    ST_READ,
    ST_SHOW
  } sfd_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic start_frame;   // start byte taken: seed checksum
    logic load_type;     // type byte taken
    logic load_id;       // id byte taken
    logic load_len;      // length byte taken, clear fill count
    logic load_payload;  // payload byte taken
    logic replay_clr;    // good frame: rewind replay index
    logic replay_read;   // read store at replay index
    logic replay_next;   // result taken: advance replay index
    logic show;          // result on the output port
  } sfd_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_start;      // incoming byte equals start value
    logic len_zero;      // incoming length byte is zero
    logic fill_done;     // this payload byte is the last one
    logic check_ok;      // checksum matches and length fits
    logic len_empty;     // held length is zero
    logic replay_last;   // current result is the last of the frame
  } sfd_status_t;

endpackage

FILE: rtl/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/sfd_datapath.sv
// ----------------------------------------------------------------------------
// sfd_datapath
// Checksum, header registers, payload store and replay index.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_datapath #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfd_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic [sfd_pkg::BYTE_W-1:0]      in_rx_byte,
  input  sfd_pkg::sfd_cmd_t               cmd,
  output sfd_pkg::sfd_status_t            status,
  output logic [sfd_pkg::BYTE_W-1:0]      out_frame_type,
  output logic [sfd_pkg::BYTE_W-1:0]      out_frame_id,
  output logic [sfd_pkg::FRAME_LEN_W-1:0] out_frame_length,
  output logic [sfd_pkg::POS_W-1:0]       out_byte_position,
  output logic [sfd_pkg::BYTE_W-1:0]      out_payload_value,
  output logic                            out_last
);
  import sfd_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [BYTE_W-1:0] CAP = BYTE_W'(MAX_PAYLOAD);

  logic [BYTE_W-1:0] start_value_r;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] type_r;
  logic [BYTE_W-1:0] id_r;
  logic [BYTE_W-1:0] len_r;
  logic [BYTE_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              store_we;
  logic [BYTE_W-1:0] ram_rdata;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_value_r <= START_RESET;
    end else if (cfg_we) begin
      start_value_r <= cfg_wdata;
    end
  end

  // running checksum and saturating fill count
  always_comb begin
    sum_nxt = sum_r;
    if (cmd.start_frame) begin
      sum_nxt = in_rx_byte;
    end else if (cmd.load_type || cmd.load_id || cmd.load_len || cmd.load_payload) begin
      sum_nxt = sum_r + in_rx_byte;
    end
    fill_nxt = (fill_r == '1) ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      type_r <= '0;
      id_r   <= '0;
      len_r  <= '0;
      fill_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      if (cmd.load_type) begin
        type_r <= in_rx_byte;
      end
      if (cmd.load_id) begin
        id_r <= in_rx_byte;
      end
      if (cmd.load_len) begin
        len_r  <= in_rx_byte;
        fill_r <= '0;
      end else if (cmd.load_payload) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // payload store, bytes beyond capacity are dropped
  assign store_we = cmd.load_payload && (fill_r < CAP);

  sfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_rx_byte),
    .re    (cmd.replay_read),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // replay index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.replay_clr) begin
      idx_nxt = '0;
    end else if (cmd.replay_next) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // status to controller
  always_comb begin
    status.is_start    = (in_rx_byte == start_value_r);
    status.len_zero    = (in_rx_byte == '0);
    status.fill_done   = (fill_nxt >= len_r);
    status.check_ok    = (sum_r == in_rx_byte) && (len_r <= CAP);
    status.len_empty   = (len_r == '0);
    status.replay_last = (len_r == '0) || ((BYTE_W'(idx_r) + 1'b1) == len_r);
  end

  // result fields
  assign out_frame_type    = type_r;
  assign out_frame_id      = id_r;
  assign out_frame_length  = len_r[FRAME_LEN_W-1:0];
  assign out_byte_position = POS_W'(idx_r);
  assign out_payload_value = (len_r == '0) ? '0 : ram_rdata;
  assign out_last          = status.replay_last;

  // a shown result always lies inside the frame
  `ASSERT_IMPL(a_idx_in_frame, clk, rst_n, cmd.show,
               len_r == '0 || BYTE_W'(idx_r) < len_r, "replay index past frame length")
  // a write never lands beyond the store
  `ASSERT_IMPL(a_store_bound, clk, rst_n, store_we,
               fill_r < CAP, "payload store write beyond capacity")

endmodule

FILE: rtl/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl
// Frame parse and replay state machine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sfd_pkg::sfd_status_t status,
  output sfd_pkg::sfd_cmd_t    cmd
);
  import sfd_pkg::*;

  sfd_state_t state_r, state_nxt;
  logic       in_fire;
  logic       out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  // bytes are taken only in parse states
  assign in_stall  = !(state_r inside {ST_START, ST_TYPE, ST_ID, ST_LEN, ST_PAYLOAD, ST_CHECK});
  assign out_valid = (state_r == ST_SHOW);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.show  = (state_r == ST_SHOW);
    case (state_r)
      ST_START: begin
        if (in_fire && status.is_start) begin
          cmd.start_frame = 1'b1;
          state_nxt       = ST_TYPE;
        end
      end
      ST_TYPE: begin
        if (in_fire) begin
          cmd.load_type = 1'b1;
          state_nxt     = ST_ID;
        end
      end
      ST_ID: begin
        if (in_fire) begin
          cmd.load_id = 1'b1;
          state_nxt   = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          cmd.load_len = 1'b1;
          state_nxt    = status.len_zero ? ST_CHECK : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (in_fire) begin
          cmd.load_payload = 1'b1;
          if (status.fill_done) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          if (status.check_ok) begin
            cmd.replay_clr = 1'b1;
            state_nxt      = status.len_empty ? ST_SHOW : ST_READ;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_READ: begin
        cmd.replay_read = 1'b1;
        state_nxt       = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_fire) begin
          if (status.replay_last) begin
            state_nxt = ST_START;
          end else begin
            cmd.replay_next = 1'b1;
            state_nxt       = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_START;
      end
    endcase
  end

  // input and output never open together
  `ASSERT_IMPL(a_one_side, clk, rst_n, out_valid, in_stall, "input open during replay")
  // a bad frame goes back to hunting
  `ASSERT_NEXT(a_bad_drop, clk, rst_n, state_r == ST_CHECK && in_fire && !status.check_ok,
               state_r == ST_START, "bad frame not dropped")
  // a taken non-final result fetches the next byte
  `ASSERT_NEXT(a_replay_step, clk, rst_n, out_fire && !status.replay_last,
               state_r == ST_READ, "replay did not advance")

endmodule

FILE: rtl/serial_frame_deframer_sum8.sv
// Timing: the first result of a good frame follows its checksum byte through ST_READ
// (payload store read) and then ST_SHOW; an empty frame goes straight to ST_SHOW.
// Throughput: one byte per cycle while parsing; during replay each result needs
// a read of the payload store's registered read port first. Input stalls in replay.
// Reset (rst_n low, synchronous): hunting for a start byte, start value 0xAA.
// ----------------------------------------------------------------------------
// serial_frame_deframer_sum8
// Byte-stream frame parser with an 8-bit additive checksum; replays good frames.
// ----------------------------------------------------------------------------
module serial_frame_deframer_sum8 #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfd_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sfd_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sfd_pkg::BYTE_W-1:0]      out_frame_type,
  output logic [sfd_pkg::BYTE_W-1:0]      out_frame_id,
  output logic [sfd_pkg::FRAME_LEN_W-1:0] out_frame_length,
  output logic [sfd_pkg::POS_W-1:0]       out_byte_position,
  output logic [sfd_pkg::BYTE_W-1:0]      out_payload_value,
  output logic                            out_last
);
  import sfd_pkg::*;

  sfd_cmd_t    cmd;
  sfd_status_t status;

  // state machine
  sfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // checksum, header, store, replay
  sfd_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .status            (status),
    .out_frame_type    (out_frame_type),
    .out_frame_id      (out_frame_id),
    .out_frame_length  (out_frame_length),
    .out_byte_position (out_byte_position),
    .out_payload_value (out_payload_value),
    .out_last          (out_last)
  );

endmodule

FILE: dv/sfd_frame_checker.sv
// ----------------------------------------------------------------------------
// sfd_frame_checker
// Watches the byte and result channels of the frame deframer, runs its own
// parser on every accepted byte and compares each replayed result, field by
// field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module sfd_frame_checker #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfd_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [sfd_pkg::BYTE_W-1:0]      in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [sfd_pkg::BYTE_W-1:0]      out_frame_type,
  input  logic [sfd_pkg::BYTE_W-1:0]      out_frame_id,
  input  logic [sfd_pkg::FRAME_LEN_W-1:0] out_frame_length,
  input  logic [sfd_pkg::POS_W-1:0]       out_byte_position,
  input  logic [sfd_pkg::BYTE_W-1:0]      out_payload_value,
  input  logic                            out_last,
  output int                              mismatches,
  output int                              results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  // one replayed payload byte as the block should present it
  typedef struct packed {
    logic [BYTE_W-1:0]      ftype;
    logic [BYTE_W-1:0]      fid;
    logic [FRAME_LEN_W-1:0] flen;
    logic [POS_W-1:0]       pos;
    logic [BYTE_W-1:0]      value;
    logic                   last;
  } replay_item_t;

  // parser copy
  sfd_state_t        parse_st;
  logic [BYTE_W-1:0] hunt_value;
  logic [BYTE_W-1:0] sum_acc;
  logic [BYTE_W-1:0] hdr_type;
  logic [BYTE_W-1:0] hdr_id;
  logic [BYTE_W-1:0] hdr_len;
  logic [BYTE_W-1:0] fill_cnt;
  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];

  replay_item_t replay_q[$];
  int           results_seen;

  task automatic log_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic replay_item_t replay_entry(input int pos, input logic [BYTE_W-1:0] value,
                                                input logic last);
    replay_item_t r;
    r.ftype = hdr_type;
    r.fid   = hdr_id;
    r.flen  = hdr_len[FRAME_LEN_W-1:0];
    r.pos   = POS_W'(pos);
    r.value = value;
    r.last  = last;
    return r;
  endfunction

  // advance the parser by one byte; a good checksum queues the replay
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    int k;
    case (parse_st)
      ST_TYPE: begin
        sum_acc  = sum_acc + b;
        hdr_type = b;
        parse_st = ST_ID;
      end
      ST_ID: begin
        sum_acc  = sum_acc + b;
        hdr_id   = b;
        parse_st = ST_LEN;
      end
      ST_LEN: begin
        sum_acc  = sum_acc + b;
        hdr_len  = b;
        fill_cnt = '0;
        parse_st = (b == 0) ? ST_CHECK : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        sum_acc = sum_acc + b;
        // bytes past capacity are summed but not stored
        if (fill_cnt < MAX_PAYLOAD)
          payload_mem[fill_cnt] = b;
        if (fill_cnt != 8'hFF)
          fill_cnt = fill_cnt + 1'b1;
        if (fill_cnt >= hdr_len)
          parse_st = ST_CHECK;
      end
      ST_CHECK: begin
        // checksum byte never restarts a frame, even when it equals the start value
        parse_st = ST_START;
        if (sum_acc == b && hdr_len <= MAX_PAYLOAD) begin
          if (hdr_len == 0)
            replay_q.push_back(replay_entry(0, '0, 1'b1));
          else
            for (k = 0; k < hdr_len; k++)
              replay_q.push_back(replay_entry(k, payload_mem[k], (k + 1 == hdr_len)));
        end
      end
      default: begin
        parse_st = ST_START;
        if (b == hunt_value) begin
          sum_acc  = b;
          parse_st = ST_TYPE;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    replay_item_t want;
    if (!rst_n) begin
      parse_st     = ST_START;
      hunt_value   = START_RESET;
      sum_acc      = '0;
      hdr_type     = '0;
      hdr_id       = '0;
      hdr_len      = '0;
      fill_cnt     = '0;
      results_seen = 0;
      replay_q.delete();
    end else begin
      if (cfg_we)
        hunt_value = cfg_wdata;
      if (in_valid && !in_stall)
        deframe_byte(in_rx_byte);
      // compare a taken result with the oldest one owed
      if (out_valid && !out_stall) begin
        if (replay_q.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with none owed (pos %0d value %0h)",
                                 results_seen, out_byte_position, out_payload_value));
        end else begin
          want = replay_q.pop_front();
          if (out_frame_type !== want.ftype)
            log_mismatch($sformatf("result %0d frame_type %0h, expected %0h",
                                   results_seen, out_frame_type, want.ftype));
          if (out_frame_id !== want.fid)
            log_mismatch($sformatf("result %0d frame_id %0h, expected %0h",
                                   results_seen, out_frame_id, want.fid));
          if (out_frame_length !== want.flen)
            log_mismatch($sformatf("result %0d frame_length %0d, expected %0d",
                                   results_seen, out_frame_length, want.flen));
          if (out_byte_position !== want.pos)
            log_mismatch($sformatf("result %0d byte_position %0d, expected %0d",
                                   results_seen, out_byte_position, want.pos));
          if (out_payload_value !== want.value)
            log_mismatch($sformatf("result %0d payload_value %0h, expected %0h",
                                   results_seen, out_payload_value, want.value));
          if (out_last !== want.last)
            log_mismatch($sformatf("result %0d last %0b, expected %0b",
                                   results_seen, out_last, want.last));
        end
        results_seen++;
      end
    end
    results_pending = replay_q.size();
  end

endmodule

FILE: dv/tb_serial_frame_deframer_sum8.sv
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_sum8
// Feeds the deframer directed and random byte streams (good frames, bad
// checksums, oversized and cut frames, noise) under several start values and
// handshake idle mixes; the checker next to the block scores every result.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_sum8;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [BYTE_W-1:0]      cfg_wdata  = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_rx_byte = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [BYTE_W-1:0]      out_frame_type;
  logic [BYTE_W-1:0]      out_frame_id;
  logic [FRAME_LEN_W-1:0] out_frame_length;
  logic [POS_W-1:0]       out_byte_position;
  logic [BYTE_W-1:0]      out_payload_value;
  logic                   out_last;

  int mismatches;
  int pending;

  int                in_idle_pct  = 0;
  int                out_idle_pct = 0;
  int                hold_req     = 0;
  int                hold_left    = 0;
  int                frame_bytes  = 0;
  logic [BYTE_W-1:0] cur_start    = START_RESET;

  always #2 clk = ~clk;

  serial_frame_deframer_sum8 #(.MAX_PAYLOAD(64)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_type   (out_frame_type),
    .out_frame_id     (out_frame_id),
    .out_frame_length (out_frame_length),
    .out_byte_position(out_byte_position),
    .out_payload_value(out_payload_value),
    .out_last         (out_last)
  );

  sfd_frame_checker #(.MAX_PAYLOAD(64)) chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_type   (out_frame_type),
    .out_frame_id     (out_frame_id),
    .out_frame_length (out_frame_length),
    .out_byte_position(out_byte_position),
    .out_payload_value(out_payload_value),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .results_pending  (pending)
  );

  // result side: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < out_idle_pct);
    end
  end

  // offer one byte, with random idle cycles first; returns at a falling edge
  // with valid dropped
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    // stall is settled at the falling edge and holds until the next rising edge
    while (in_stall) @(negedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] free_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    if (b == cur_start)
      b = ~b;
    return b;
  endfunction

  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++)
      push_byte(free_byte());
  endtask

  // whole frame with random payload; bad spoils the checksum
  task automatic send_frame(input logic [BYTE_W-1:0] ftype, input logic [BYTE_W-1:0] fid,
                            input int len, input bit bad);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int                i;
    sum = cur_start;
    push_byte(cur_start);
    sum = sum + ftype;
    push_byte(ftype);
    sum = sum + fid;
    push_byte(fid);
    sum = sum + BYTE_W'(len);
    push_byte(BYTE_W'(len));
    for (i = 0; i < len; i++) begin
      b   = BYTE_W'($urandom);
      sum = sum + b;
      push_byte(b);
    end
    if (bad)
      sum = sum + BYTE_W'($urandom_range(1, 255));
    push_byte(sum);
    frame_bytes += len + 5;
  endtask

  // let owed results drain, then let the block settle
  task automatic wait_idle(input int settle);
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_start(input logic [BYTE_W-1:0] v);
    wait_idle(8);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_start = v;
  endtask

  // mostly good frames with random content, the rest broken or noise
  task automatic run_random(input int target);
    int stop;
    int r;
    int len;
    int cut;
    int i;
    stop = frame_bytes + target;
    while (frame_bytes < stop) begin
      r = $urandom_range(99);
      if (r < 65) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
        send_frame(BYTE_W'($urandom), BYTE_W'($urandom), len, 1'b0);
      end else if (r < 75) begin
        send_frame(BYTE_W'($urandom), BYTE_W'($urandom), $urandom_range(0, 8), 1'b1);
      end else if (r < 82) begin
        // oversized: dropped whatever the checksum
        send_frame(BYTE_W'($urandom), BYTE_W'($urandom), $urandom_range(65, 72),
                   1'($urandom_range(1)));
      end else if (r < 90) begin
        // header, part of the payload, then filler long enough to resync
        len = $urandom_range(0, 4);
        cut = $urandom_range(0, len);
        push_byte(cur_start);
        push_byte(BYTE_W'($urandom));
        push_byte(BYTE_W'($urandom));
        push_byte(BYTE_W'(len));
        for (i = 0; i < cut; i++)
          push_byte(BYTE_W'($urandom));
        send_noise(6);
        frame_bytes += 4 + cut;
      end else begin
        send_noise($urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    int ph;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct  = 21;
    out_idle_pct = 62;

    // directed: stray byte, empty frame whose checksum equals the start value,
    // field extremes, bad checksum
    push_byte(8'h00);
    send_frame(8'h00, 8'h00, 0, 1'b0);
    send_frame(8'hFF, 8'h00, 1, 1'b0);
    send_frame(8'h5A, 8'hFF, 2, 1'b0);
    send_frame(8'h01, 8'h02, 1, 1'b1);

    // long output hold-off while frames keep coming: input must back up
    hold_req = 300;
    send_frame(BYTE_W'($urandom), BYTE_W'($urandom), 24, 1'b0);
    send_frame(BYTE_W'($urandom), BYTE_W'($urandom), 3, 1'b0);

    run_random(20);

    for (ph = 1; ph < 6; ph++) begin
      if (ph == 2) begin
        in_idle_pct  = 62;
        out_idle_pct = 21;
      end else if (ph == 4) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (ph)
        1:       set_start(8'h00);
        2:       set_start(8'hFF);
        default: set_start(BYTE_W'($urandom));
      endcase
      if (ph == 5) begin
        // full-capacity frame, then a long oversized one
        send_frame(BYTE_W'($urandom), BYTE_W'($urandom), 64, 1'b0);
        send_frame(BYTE_W'($urandom), BYTE_W'($urandom), $urandom_range(128, 160),
                   1'($urandom_range(1)));
      end
      run_random(20);
    end

    in_valid = 1'b0;
    wait_idle(20);

    if (mismatches == 0 && pending == 0)
      $display("PASS serial_frame_deframer_sum8");
    else
      $display("FAIL serial_frame_deframer_sum8");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL serial_frame_deframer_sum8");
    $finish;
  end

endmodule
